@@ rtl/cauchy_to_pk2_stress_transform_assert.svh @@
// Assertion macros for the stress pull-back block.
// Included by the checker module; depends on nothing else.
`ifndef CAUCHY_TO_PK2_STRESS_TRANSFORM_ASSERT_SVH
`define CAUCHY_TO_PK2_STRESS_TRANSFORM_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define C2PK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2pk check failed");

// The consequent holds in the cycle after the antecedent.
`define C2PK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2pk check failed");

`endif

@@ rtl/c2pk_pkg.sv @@
// Shared constants, types and the microprogram of the stress pull-back block.
// Depends on nothing; imported by the top level.
package c2pk_pkg;

    localparam int FRAC_BITS = 32;
    localparam int DATA_W    = 64;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] GRP_COF = 2'd0;
    localparam logic [1:0] GRP_DET = 2'd1;
    localparam logic [1:0] GRP_BIL = 2'd2;

    localparam logic [0:0] REG_COUNT = 1'd0;
    localparam logic [0:0] REG_PLANE = 1'd1;

    localparam logic [4:0] A_F8  = 5'd8;
    localparam logic [4:0] A_SA  = 5'd9;
    localparam logic [4:0] A_SB  = 5'd10;
    localparam logic [4:0] A_SC  = 5'd11;
    localparam logic [4:0] A_SD  = 5'd12;
    localparam logic [4:0] A_SF  = 5'd13;
    localparam logic [4:0] A_SE  = 5'd14;
    localparam logic [4:0] A_STR = 5'd15;
    localparam logic [4:0] A_C0  = 5'd16;
    localparam logic [4:0] A_J   = 5'd25;
    localparam logic [4:0] A_T1  = 5'd26;
    localparam logic [4:0] A_T2  = 5'd27;
    localparam logic [4:0] A_I1  = 5'd28;
    localparam logic [4:0] A_I0  = 5'd29;
    localparam logic [4:0] A_I2  = 5'd30;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] dst;
        logic [4:0] a;
        logic [4:0] b;
    } instr_t;

    function automatic instr_t mk(logic [1:0] op, logic [4:0] dst, logic [4:0] a,
                                  logic [4:0] b);
        instr_t r;
        r.op = op;
        r.dst = dst;
        r.a = a;
        r.b = b;
        return r;
    endfunction

    function automatic instr_t dot3(logic [4:0] x0, logic [4:0] y0, logic [4:0] x1,
                                    logic [4:0] y1, logic [4:0] x2, logic [4:0] y2,
                                    logic [4:0] dst, logic [2:0] stp);
        instr_t r;
        case (stp)
            3'd0:    r = mk(OP_MUL, A_T1, x0, y0);
            3'd1:    r = mk(OP_MUL, A_T2, x1, y1);
            3'd2:    r = mk(OP_ADD, A_T1, A_T1, A_T2);
            3'd3:    r = mk(OP_MUL, A_T2, x2, y2);
            default: r = mk(OP_ADD, dst, A_T1, A_T2);
        endcase
        return r;
    endfunction

    // Cofactor k is f[a]*f[b] - f[c]*f[d].
    function automatic logic [19:0] cof_row(logic [3:0] k);
        logic [19:0] r;
        case (k)
            4'd0:    r = {5'd4, 5'd8, 5'd5, 5'd7};
            4'd1:    r = {5'd2, 5'd7, 5'd1, 5'd8};
            4'd2:    r = {5'd1, 5'd5, 5'd2, 5'd4};
            4'd3:    r = {5'd5, 5'd6, 5'd3, 5'd8};
            4'd4:    r = {5'd0, 5'd8, 5'd2, 5'd6};
            4'd5:    r = {5'd2, 5'd3, 5'd0, 5'd5};
            4'd6:    r = {5'd3, 5'd7, 5'd4, 5'd6};
            4'd7:    r = {5'd1, 5'd6, 5'd0, 5'd7};
            default: r = {5'd0, 5'd4, 5'd1, 5'd3};
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rv(logic [1:0] i, logic [1:0] m);
        return 5'(A_C0 + 5'(i) + 5'(m) * 5'd3);
    endfunction

    function automatic instr_t prog(logic [1:0] grp, logic [3:0] idx, logic [2:0] sub,
                                    logic [2:0] stp);
        instr_t r;
        logic [19:0] row;
        logic [1:0] u;
        logic [1:0] v;
        row = cof_row(idx);
        case (idx)
            4'd1:    begin u = 2'd1; v = 2'd1; end
            4'd2:    begin u = 2'd2; v = 2'd2; end
            4'd3:    begin u = 2'd0; v = 2'd1; end
            4'd4:    begin u = 2'd1; v = 2'd2; end
            4'd5:    begin u = 2'd0; v = 2'd2; end
            default: begin u = 2'd0; v = 2'd0; end
        endcase
        if (grp == GRP_COF) begin
            case (stp)
                3'd0:    r = mk(OP_MUL, A_T1, row[19:15], row[14:10]);
                3'd1:    r = mk(OP_MUL, A_T2, row[9:5], row[4:0]);
                default: r = mk(OP_SUB, 5'(A_C0 + 5'(idx)), A_T1, A_T2);
            endcase
        end else if (grp == GRP_DET) begin
            r = dot3(5'd0, A_C0, 5'd3, 5'(A_C0 + 5'd1), 5'd6, 5'(A_C0 + 5'd2), A_J, stp);
        end else begin
            case (sub)
                3'd0:    r = dot3(A_SF, rv(v, 2'd2), A_SB, rv(v, 2'd1), A_SD, rv(v, 2'd0),
                              A_I1, stp);
                3'd1:    r = dot3(A_SE, rv(v, 2'd2), A_SD, rv(v, 2'd1), A_SA, rv(v, 2'd0),
                              A_I0, stp);
                3'd2:    r = dot3(A_SC, rv(v, 2'd2), A_SF, rv(v, 2'd1), A_SE, rv(v, 2'd0),
                              A_I2, stp);
                3'd3:    r = dot3(rv(u, 2'd1), A_I1, rv(u, 2'd0), A_I0, rv(u, 2'd2), A_I2,
                              A_T1, stp);
                default: r = mk(OP_DIV, A_T1, A_T1, A_J);
            endcase
        end
        return r;
    endfunction

endpackage

@@ rtl/cauchy_to_pk2_stress_transform.sv @@
// Top level of the Cauchy to second Piola-Kirchhoff stress pull-back block.
// Depends on c2pk_pkg for the microprogram, operation codes and constants.
//
// Channel   Direction  Handshake              Payload
// operand   in         start / busy           operand_slot, operand_value, last_operand
// result    out        result_strobe          component_index, component_value,
//                                             last_component, singular
// config    in         cfg_write_en           cfg_index, cfg_data
//
// A last load runs the microprogram on a single shared unit: a multiply accumulates 4
// partial products of a 32 by 32 multiplier, and a divide uses a restoring divider with
// one quotient bit a cycle.
// Reset clears the operand store and sets the registers to their defaults.
// Results are strobed for one cycle each and cannot be stalled.
module cauchy_to_pk2_stress_transform
    import c2pk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [3:0]              operand_slot,
    input  logic signed [DATA_W-1:0] operand_value,
    input  logic                    last_operand,
    input  logic                    cfg_write_en,
    input  logic [0:0]              cfg_index,
    input  logic [2:0]              cfg_data,
    output logic                    result_strobe,
    output logic [2:0]              component_index,
    output logic signed [DATA_W-1:0] component_value,
    output logic                    last_component,
    output logic                    singular
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_READ = 4'd1;
    localparam logic [3:0] ST_MSET = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_RND  = 4'd4;
    localparam logic [3:0] ST_ALU  = 4'd5;
    localparam logic [3:0] ST_DSET = 4'd6;
    localparam logic [3:0] ST_DINI = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_DEND = 4'd9;
    localparam logic [3:0] ST_EZ   = 4'd10;

    localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
    localparam logic [63:0] MIN_NEG = {1'b1, {63{1'b0}}};

    logic [3:0]  state_reg, state_next;
    logic [1:0]  grp_reg, grp_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  sub_reg, sub_next;
    logic [2:0]  stp_reg, stp_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  count_reg;
    logic        plane_reg;
    logic [63:0] regs [32];
    logic [63:0] op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic [63:0] mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic        neg_reg, neg_next, ovf_reg, ovf_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next, lo_reg, lo_next, q_reg, q_next;
    logic        res_strobe_reg, res_strobe_next;
    logic [2:0]  res_index_reg, res_index_next;
    logic [63:0] res_value_reg, res_value_next;
    logic        res_last_reg, res_last_next;
    logic        res_sing_reg, res_sing_next;

    instr_t      ins;
    logic        wr_en;
    logic [63:0] wr_data;
    logic [3:0]  last_idx;
    logic        load;

    function automatic logic [63:0] mag_of(logic [63:0] x);
        return x[63] ? 64'(-x) : x;
    endfunction

    function automatic logic [63:0] pack(logic neg, logic ovf, logic [63:0] mag);
        logic [63:0] r;
        if (!neg) begin
            r = (ovf || mag[63]) ? MAX_POS : mag;
        end else begin
            r = (ovf || mag[63]) ? MIN_NEG : 64'(-mag);
        end
        return r;
    endfunction

    function automatic logic [63:0] rd_op(logic [4:0] addr, logic [2:0] cnt, logic plane,
                                          logic [63:0] data_f8, logic [63:0] data_str,
                                          logic [63:0] data);
        logic [63:0] r;
        r = data;
        if (addr == A_F8 && plane) begin
            r = data_str;
        end else if (addr == A_F8) begin
            r = data_f8;
        end
        if (addr == A_SD && cnt < 3'd4) begin
            r = '0;
        end
        if ((addr == A_SF || addr == A_SE) && cnt != 3'd6) begin
            r = '0;
        end
        return r;
    endfunction

    logic [31:0]  mul_x, mul_y;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rsum;
    logic [64:0]  asum;
    logic [64:0]  remw;

    always_comb
    begin
        ins = prog(grp_reg, idx_reg, sub_reg, stp_reg);
        load = start && (state_reg == ST_IDLE);
        busy = (state_reg != ST_IDLE);
        last_idx = (count_reg == 3'd6) ? 4'd5 : ((count_reg == 3'd4) ? 4'd3 : 4'd2);

        mul_x = cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
        mul_y = cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
        pp = 64'(mul_x) * 64'(mul_y);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rsum = acc_reg + (128'd1 << (FRAC_BITS - 1));
        if (ins.op == OP_SUB) begin
            asum = {op_a_reg[63], op_a_reg} - {op_b_reg[63], op_b_reg};
        end else begin
            asum = {op_a_reg[63], op_a_reg} + {op_b_reg[63], op_b_reg};
        end
        remw = {rem_reg, lo_reg[63]};

        state_next = state_reg;
        grp_next = grp_reg;
        idx_next = idx_reg;
        sub_next = sub_reg;
        stp_next = stp_reg;
        cnt_next = cnt_reg;
        op_a_next = op_a_reg;
        op_b_next = op_b_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next = neg_reg;
        ovf_next = ovf_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        lo_next = lo_reg;
        q_next = q_reg;
        res_strobe_next = 1'b0;
        res_index_next = res_index_reg;
        res_value_next = res_value_reg;
        res_last_next = res_last_reg;
        res_sing_next = res_sing_reg;
        wr_en = 1'b0;
        wr_data = '0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (load && last_operand) begin
                    state_next = ST_READ;
                    grp_next = GRP_COF;
                    idx_next = '0;
                    sub_next = '0;
                    stp_next = '0;
                end
            end
            ST_READ:
            begin
                op_a_next = rd_op(ins.a, count_reg, plane_reg, regs[A_F8], regs[A_STR],
                                  regs[ins.a]);
                op_b_next = rd_op(ins.b, count_reg, plane_reg, regs[A_F8], regs[A_STR],
                                  regs[ins.b]);
                if (ins.op == OP_MUL) begin
                    state_next = ST_MSET;
                end else if (ins.op == OP_DIV) begin
                    state_next = ST_DSET;
                end else begin
                    state_next = ST_ALU;
                end
            end
            ST_MSET, ST_DSET:
            begin
                mag_a_next = mag_of(op_a_reg);
                mag_b_next = mag_of(op_b_reg);
                neg_next = op_a_reg[63] ^ op_b_reg[63];
                cnt_next = '0;
                acc_next = '0;
                state_next = (state_reg == ST_MSET) ? ST_MUL : ST_DINI;
            end
            ST_MUL:
            begin
                acc_next = acc_reg + pp_sh;
                cnt_next = 6'(cnt_reg + 6'd1);
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = ST_RND;
                end
            end
            ST_RND, ST_ALU:
            begin
                wr_en = 1'b1;
                if (state_reg == ST_RND) begin
                    wr_data = pack(neg_reg, |rsum[127:FRAC_BITS+64],
                                   rsum[FRAC_BITS+63:FRAC_BITS]);
                end else if (asum[64] != asum[63]) begin
                    wr_data = asum[64] ? MIN_NEG : MAX_POS;
                end else begin
                    wr_data = asum[63:0];
                end
                state_next = ST_READ;
                if (grp_reg == GRP_COF) begin
                    if (stp_reg == 3'd2) begin
                        stp_next = '0;
                        if (idx_reg == 4'd8) begin
                            grp_next = GRP_DET;
                            idx_next = '0;
                        end else begin
                            idx_next = 4'(idx_reg + 4'd1);
                        end
                    end else begin
                        stp_next = 3'(stp_reg + 3'd1);
                    end
                end else if (stp_reg == 3'd4) begin
                    stp_next = '0;
                    if (grp_reg == GRP_DET) begin
                        grp_next = GRP_BIL;
                        idx_next = '0;
                        sub_next = '0;
                        if (wr_data == '0) begin
                            state_next = ST_EZ;
                        end
                    end else begin
                        sub_next = 3'(sub_reg + 3'd1);
                    end
                end else begin
                    stp_next = 3'(stp_reg + 3'd1);
                end
            end
            ST_DINI:
            begin
                rem_next = mag_a_reg >> (DATA_W - FRAC_BITS);
                lo_next = mag_a_reg << FRAC_BITS;
                q_next = '0;
                ovf_next = ((mag_a_reg >> (DATA_W - FRAC_BITS)) >= mag_b_reg);
                cnt_next = '0;
                state_next = ((mag_a_reg >> (DATA_W - FRAC_BITS)) >= mag_b_reg)
                             ? ST_DEND : ST_DIV;
            end
            ST_DIV:
            begin
                lo_next = {lo_reg[62:0], 1'b0};
                if (remw >= {1'b0, mag_b_reg}) begin
                    rem_next = 64'(remw - {1'b0, mag_b_reg});
                    q_next = {q_reg[62:0], 1'b1};
                end else begin
                    rem_next = remw[63:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
                cnt_next = 6'(cnt_reg + 6'd1);
                if (cnt_reg == 6'd63) begin
                    state_next = ST_DEND;
                end
            end
            ST_DEND, ST_EZ:
            begin
                res_strobe_next = 1'b1;
                res_index_next = idx_reg[2:0];
                res_last_next = (idx_reg == last_idx);
                res_sing_next = (state_reg == ST_EZ);
                if (state_reg == ST_EZ
                    || (count_reg == 3'd4 && plane_reg && idx_reg == 4'd2)) begin
                    res_value_next = '0;
                end else begin
                    res_value_next = pack(neg_reg, ovf_reg, q_reg);
                end
                if (idx_reg == last_idx) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = 4'(idx_reg + 4'd1);
                    sub_next = '0;
                    stp_next = '0;
                    if (state_reg == ST_DEND) begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 32; i++) begin
                regs[i] <= '0;
            end
        end else if (load) begin
            regs[{1'b0, operand_slot}] <= operand_value;
        end else if (wr_en) begin
            regs[ins.dst] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            grp_reg <= GRP_COF;
            idx_reg <= '0;
            sub_reg <= '0;
            stp_reg <= '0;
            cnt_reg <= '0;
            count_reg <= 3'd6;
            plane_reg <= 1'b0;
            res_strobe_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            grp_reg <= grp_next;
            idx_reg <= idx_next;
            sub_reg <= sub_next;
            stp_reg <= stp_next;
            cnt_reg <= cnt_next;
            res_strobe_reg <= res_strobe_next;
            if (cfg_write_en) begin
                unique case (cfg_index)
                    REG_COUNT: count_reg <= cfg_data;
                    REG_PLANE: plane_reg <= cfg_data[0];
                    default:   count_reg <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg <= op_a_next;
        op_b_reg <= op_b_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        q_reg <= q_next;
        res_index_reg <= res_index_next;
        res_value_reg <= res_value_next;
        res_last_reg <= res_last_next;
        res_sing_reg <= res_sing_next;
    end

    assign result_strobe = res_strobe_reg;
    assign component_index = res_index_reg;
    assign component_value = res_value_reg;
    assign last_component = res_last_reg;
    assign singular = res_sing_reg;

endmodule

@@ rtl/c2pk_checker.sv @@
// Port-level checker for the stress pull-back block, bound to the top level.
// Depends on cauchy_to_pk2_stress_transform_assert.svh for the assertion macros.
`include "cauchy_to_pk2_stress_transform_assert.svh"

module c2pk_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last_operand,
    input logic        result_strobe,
    input logic        last_component,
    input logic        singular,
    input logic [63:0] component_value
);

    `C2PK_ASSERT_NOW(a_run_open, clk, rst_n, result_strobe && !last_component, busy)
    `C2PK_ASSERT_NOW(a_sing_zero, clk, rst_n, result_strobe && singular,
        component_value == 64'd0)
    `C2PK_ASSERT_NEXT(a_plain_load, clk, rst_n, start && !busy && !last_operand,
        !busy && !result_strobe)
    `C2PK_ASSERT_NEXT(a_last_load, clk, rst_n, start && !busy && last_operand,
        busy && !result_strobe)

endmodule

bind cauchy_to_pk2_stress_transform c2pk_checker u_c2pk_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .last_operand    (last_operand),
    .result_strobe   (result_strobe),
    .last_component  (last_component),
    .singular        (singular),
    .component_value (component_value)
);

@@ tb/sv/cauchy_to_pk2_stress_transform_tb.sv @@
// Self-checking testbench for the Cauchy to second Piola-Kirchhoff stress pull-back block.
// It predicts every result run from its own fixed-point model of the transform.
// Depends on c2pk_pkg and the top level cauchy_to_pk2_stress_transform.
`timescale 1ns / 1ps

module cauchy_to_pk2_stress_transform_tb;
    import c2pk_pkg::*;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic [DATA_W-1:0] umag_t;

    typedef struct {
        logic [2:0] index;
        fix_t       value;
        logic       last;
        logic       sing;
    } stress_out_t;

    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam fix_t FIX_ONE = fix_t'(1) <<< FRAC_BITS;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [3:0]               operand_slot;
    logic signed [DATA_W-1:0] operand_value;
    logic                     last_operand;
    logic                     cfg_write_en;
    logic [0:0]               cfg_index;
    logic [2:0]               cfg_data;
    logic                     result_strobe;
    logic [2:0]               component_index;
    logic signed [DATA_W-1:0] component_value;
    logic                     last_component;
    logic                     singular;

    fix_t        slot_store [16];
    logic [2:0]  model_count;
    logic        model_plane;
    stress_out_t pending_stress [$];
    int          err_count;
    int          gap_pct;

    cauchy_to_pk2_stress_transform dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operand_slot    (operand_slot),
        .operand_value   (operand_value),
        .last_operand    (last_operand),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_strobe   (result_strobe),
        .component_index (component_index),
        .component_value (component_value),
        .last_component  (last_component),
        .singular        (singular)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic umag_t mag(fix_t x);
        return x < 0 ? umag_t'(-x) : umag_t'(x);
    endfunction

    function automatic fix_t sat_pack(logic neg, logic ovf, umag_t m);
        if (!neg)
        begin
            return (ovf || m > umag_t'(FIX_MAX)) ? FIX_MAX : fix_t'(m);
        end
        return (ovf || m[DATA_W-1]) ? FIX_MIN : -fix_t'(m);
    endfunction

    function automatic fix_t fx_mul(fix_t a, fix_t b);
        logic [2*DATA_W-1:0] p;
        p = {{DATA_W{1'b0}}, mag(a)} * {{DATA_W{1'b0}}, mag(b)};
        p = p + ({{(2*DATA_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
        p = p >> FRAC_BITS;
        return sat_pack((a < 0) != (b < 0), p[2*DATA_W-1:DATA_W] != 0, p[DATA_W-1:0]);
    endfunction

    function automatic fix_t fx_add(fix_t a, fix_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s > $signed({1'b0, FIX_MAX}))
        begin
            return FIX_MAX;
        end
        if (s < $signed({1'b1, FIX_MIN}))
        begin
            return FIX_MIN;
        end
        return fix_t'(s);
    endfunction

    function automatic fix_t fx_sub(fix_t a, fix_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s > $signed({1'b0, FIX_MAX}))
        begin
            return FIX_MAX;
        end
        if (s < $signed({1'b1, FIX_MIN}))
        begin
            return FIX_MIN;
        end
        return fix_t'(s);
    endfunction

    function automatic fix_t fx_div(fix_t num, fix_t den);
        umag_t               un;
        umag_t               ud;
        logic [2*DATA_W-1:0] q;
        logic                neg;
        un = mag(num);
        ud = mag(den);
        neg = (num < 0) != (den < 0);
        if ((un >> (DATA_W - FRAC_BITS)) >= ud)
        begin
            return sat_pack(neg, 1'b1, '0);
        end
        q = ({{DATA_W{1'b0}}, un} << FRAC_BITS) / {{DATA_W{1'b0}}, ud};
        return sat_pack(neg, 1'b0, q[DATA_W-1:0]);
    endfunction

    // Quadratic form u * sigma * v with the stress in the order that the microprogram uses.
    function automatic fix_t stress_form(fix_t sg[6], fix_t u[3], fix_t v[3]);
        fix_t i0;
        fix_t i1;
        fix_t i2;
        i1 = fx_add(fx_add(fx_mul(sg[5], v[2]), fx_mul(sg[1], v[1])), fx_mul(sg[3], v[0]));
        i0 = fx_add(fx_add(fx_mul(sg[4], v[2]), fx_mul(sg[3], v[1])), fx_mul(sg[0], v[0]));
        i2 = fx_add(fx_add(fx_mul(sg[2], v[2]), fx_mul(sg[5], v[1])), fx_mul(sg[4], v[0]));
        return fx_add(fx_add(fx_mul(u[1], i1), fx_mul(u[0], i0)), fx_mul(u[2], i2));
    endfunction

    function automatic fix_t cof(fix_t f[9], int a, int b, int c, int d);
        return fx_sub(fx_mul(f[a], f[b]), fx_mul(f[c], f[d]));
    endfunction

    task automatic predict_pullback(logic [3:0] slot, fix_t value, logic last);
        fix_t        f [9];
        fix_t        cf [9];
        fix_t        sg [6];
        fix_t        rw [3][3];
        fix_t        res [6];
        fix_t        det;
        int          n;
        stress_out_t e;
        slot_store[slot] = value;
        if (!last)
        begin
            return;
        end
        for (int k = 0; k < 9; k++)
        begin
            f[k] = slot_store[k];
        end
        if (model_plane)
        begin
            f[8] = slot_store[15];
        end
        cf[0] = cof(f, 4, 8, 5, 7);
        cf[1] = cof(f, 2, 7, 1, 8);
        cf[2] = cof(f, 1, 5, 2, 4);
        cf[3] = cof(f, 5, 6, 3, 8);
        cf[4] = cof(f, 0, 8, 2, 6);
        cf[5] = cof(f, 2, 3, 0, 5);
        cf[6] = cof(f, 3, 7, 4, 6);
        cf[7] = cof(f, 1, 6, 0, 7);
        cf[8] = cof(f, 0, 4, 1, 3);
        det = fx_add(fx_add(fx_mul(f[0], cf[0]), fx_mul(f[3], cf[1])), fx_mul(f[6], cf[2]));
        sg[0] = slot_store[9];
        sg[1] = slot_store[10];
        sg[2] = slot_store[11];
        sg[3] = model_count >= 4 ? slot_store[12] : '0;
        sg[4] = model_count == 6 ? slot_store[14] : '0;
        sg[5] = model_count == 6 ? slot_store[13] : '0;
        for (int k = 0; k < 3; k++)
        begin
            rw[k][0] = cf[k];
            rw[k][1] = cf[k + 3];
            rw[k][2] = cf[k + 6];
        end
        n = model_count == 6 ? 6 : (model_count == 4 ? 4 : 3);
        for (int k = 0; k < 6; k++)
        begin
            res[k] = '0;
        end
        if (det != 0)
        begin
            res[0] = fx_div(stress_form(sg, rw[0], rw[0]), det);
            res[1] = fx_div(stress_form(sg, rw[1], rw[1]), det);
            res[2] = fx_div(stress_form(sg, rw[2], rw[2]), det);
            res[3] = fx_div(stress_form(sg, rw[0], rw[1]), det);
            res[4] = fx_div(stress_form(sg, rw[1], rw[2]), det);
            res[5] = fx_div(stress_form(sg, rw[0], rw[2]), det);
            if (model_count == 4 && model_plane)
            begin
                res[2] = '0;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            e.index = 3'(k);
            e.value = res[k];
            e.last = (k == n - 1);
            e.sing = (det == 0);
            pending_stress.push_back(e);
        end
    endtask

    always @(posedge clk)
    begin
        stress_out_t e;
        if (rst_n && result_strobe)
        begin
            if (pending_stress.size() == 0)
            begin
                $error("unexpected result: component_index %0d", component_index);
                err_count++;
            end
            else
            begin
                e = pending_stress.pop_front();
                if (component_index !== e.index)
                begin
                    $error("component_index expected %0d actual %0d", e.index, component_index);
                    err_count++;
                end
                if (component_value !== e.value)
                begin
                    $error("component_value expected %0h actual %0h", e.value, component_value);
                    err_count++;
                end
                if (last_component !== e.last)
                begin
                    $error("last_component expected %0b actual %0b", e.last, last_component);
                    err_count++;
                end
                if (singular !== e.sing)
                begin
                    $error("singular expected %0b actual %0b", e.sing, singular);
                    err_count++;
                end
            end
        end
    end

    task automatic load_operand(logic [3:0] slot, fix_t value, logic last);
        @(negedge clk);
        start <= 1'b1;
        operand_slot <= slot;
        operand_value <= value;
        last_operand <= last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        predict_pullback(slot, value, last);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_stress.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(logic [0:0] idx, logic [2:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_COUNT)
        begin
            model_count = data;
        end
        else
        begin
            model_plane = data[0];
        end
    endtask

    task automatic set_mode(logic [2:0] count, logic plane);
        drain_results();
        write_register(REG_COUNT, count);
        write_register(REG_PLANE, {2'b00, plane});
    endtask

    function automatic fix_t pick_value(logic [3:0] slot);
        fix_t v;
        case ($urandom_range(0, 9))
            0:       v = FIX_MAX;
            1:       v = FIX_MIN;
            2:       v = '0;
            3:       v = {$urandom, $urandom};
            default: v = fix_t'($signed($urandom_range(0, 8)) - 4) * FIX_ONE
                         + fix_t'($urandom_range(0, 32'hffff_ffff));
        endcase
        if (slot < 9 && $urandom_range(0, 3) != 0)
        begin
            v = (slot % 4 == 0) ? fix_t'($urandom_range(1, 3)) * FIX_ONE
                                : fix_t'($signed($urandom_range(0, 2)) - 1) * (FIX_ONE >>> 2);
        end
        return v;
    endfunction

    task automatic test_directed();
        fix_t neg_half;
        neg_half = -(FIX_ONE >>> 1);
        gap_pct = 0;
        load_operand(4'd0, FIX_ONE, 1'b0);
        load_operand(4'd4, FIX_ONE, 1'b0);
        load_operand(4'd8, 2 * FIX_ONE, 1'b0);
        load_operand(4'd9, 3 * FIX_ONE, 1'b0);
        load_operand(4'd10, neg_half, 1'b0);
        load_operand(4'd11, FIX_ONE, 1'b0);
        load_operand(4'd12, FIX_ONE >>> 3, 1'b0);
        load_operand(4'd13, neg_half, 1'b0);
        load_operand(4'd14, FIX_ONE, 1'b1);
        set_mode(3'd4, 1'b1);
        load_operand(4'd15, FIX_ONE >>> 1, 1'b1);
        set_mode(3'd3, 1'b0);
        load_operand(4'd9, FIX_MAX, 1'b1);
        set_mode(3'd5, 1'b0);
        load_operand(4'd10, FIX_MIN, 1'b1);
        set_mode(3'd7, 1'b1);
        load_operand(4'd12, neg_half, 1'b1);
        set_mode(3'd0, 1'b0);
        load_operand(4'd11, -FIX_ONE, 1'b1);
        set_mode(3'd6, 1'b0);
        load_operand(4'd4, '0, 1'b1);
        load_operand(4'd4, FIX_ONE, 1'b0);
        load_operand(4'd3, FIX_MAX, 1'b0);
        load_operand(4'd1, FIX_MIN, 1'b0);
        load_operand(4'd0, -FIX_ONE, 1'b1);
        load_operand(4'd0, FIX_MAX, 1'b1);
        drain_results();
    endtask

    task automatic test_random(int n_items, int pct);
        int sent;
        int len;
        gap_pct = pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                set_mode(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len; k++)
                begin
                    logic [3:0] slot;
                    slot = 4'($urandom_range(0, 15));
                    load_operand(slot, pick_value(slot), k == len - 1);
                end
                sent += len;
            end
            else
            begin
                logic [3:0] slot;
                slot = 4'($urandom_range(0, 15));
                load_operand(slot, pick_value(slot), $urandom_range(0, 3) == 0);
                sent++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        err_count = 0;
        gap_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operand_slot = '0;
        operand_value = '0;
        last_operand = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int k = 0; k < 16; k++)
        begin
            slot_store[k] = '0;
        end
        model_count = 3'd6;
        model_plane = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(85, 28);
        test_random(85, 56);
        test_random(85, 0);
        repeat (200) @(posedge clk);
        if (pending_stress.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_stress.size());
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/c2pk_pkg.sv
rtl/cauchy_to_pk2_stress_transform.sv
rtl/c2pk_checker.sv
tb/sv/cauchy_to_pk2_stress_transform_tb.sv
